// File: rtl/lsegt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsegt_pkg: shared types and constants
// Field widths, opcodes, controller states and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package lsegt_pkg;

    localparam int OPCODE_W = 2;
    localparam int RANGE_W  = 11;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 64;
    localparam int SIZE_W   = 11;

    localparam logic [SIZE_W-1:0]   ACTIVE_SIZE_RESET = 11'd1024;

    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'h0001,
        S_IDLE     = 15'h0002,
        S_DISPATCH = 15'h0004,
        S_AMUL_LO  = 15'h0008,
        S_AMUL_HI  = 15'h0010,
        S_USETUP   = 15'h0020,
        S_URD      = 15'h0040,
        S_UWR      = 15'h0080,
        S_QSETUP   = 15'h0100,
        S_QRD      = 15'h0200,
        S_QACC     = 15'h0400,
        S_QMUL_LO  = 15'h0800,
        S_QMUL_HI  = 15'h1000,
        S_QCOMB    = 15'h2000,
        S_DONE     = 15'h4000
    } lsegt_state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mul_lo;
        logic mul_hi;
        logic mul_acc;
        logic upd_setup;
        logic rd;
        logic upd_wr;
        logic qry_setup;
        logic qry_acc;
        logic combine;
        logic second;
        logic out_load;
    } lsegt_cmd_t;

    typedef struct packed {
        logic is_add;
        logic is_query;
        logic is_clear;
        logic empty;
        logic upd_done;
        logic qry_done;
        logic clr_last;
    } lsegt_status_t;

endpackage

// File: rtl/lsegt_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// lsegt_dp: range add and range sum datapath
// Holds the node memory as two interleaved binary indexed trees, the
// operand registers, a shared split multiplier and the result register.
// ============================================================================
module lsegt_dp #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsegt_pkg::lsegt_cmd_t             cmd,
    output lsegt_pkg::lsegt_status_t          status,
    input  logic [lsegt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [lsegt_pkg::RANGE_W-1:0]     range_low,
    input  logic [lsegt_pkg::RANGE_W-1:0]     range_high,
    input  logic signed [lsegt_pkg::VALUE_W-1:0] add_value,
    input  logic                              active_size_wr_en,
    input  logic [lsegt_pkg::SIZE_W-1:0]      active_size,
    output logic signed [lsegt_pkg::SUM_W-1:0] range_sum
);

    localparam int IW = $clog2(2 * LEAF_COUNT + 1);
    localparam int AW = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
    localparam int RW = lsegt_pkg::RANGE_W;
    localparam int SW = lsegt_pkg::SUM_W;
    localparam int PW = 32 + IW;

    logic [SW*2-1:0] mem [LEAF_COUNT];

    logic [lsegt_pkg::SIZE_W-1:0]   active_size_reg;
    logic [lsegt_pkg::OPCODE_W-1:0] op_reg;
    logic                           empty_reg;
    logic [IW-1:0]                  lo_reg, hi_reg, idx_reg, mpos_reg;
    logic [SW-1:0]                  v_reg, d1_reg, d2_reg;
    logic [SW-1:0]                  acc1_reg, acc2_reg, total_reg, prod_reg, sum_reg;
    logic [SW*2-1:0]                rdata_reg;

    logic [RW-1:0] eff, lo_c, hi_c;
    logic          empty;
    logic [IW-1:0] lowbit, idx_m1;
    logic [AW-1:0] addr;
    logic [SW-1:0] mul_a, diff;
    logic [31:0]   mul_half;
    logic [PW-1:0] pp;

    always_comb
    begin
        eff    = (32'(active_size_reg) > LEAF_COUNT) ? RW'(LEAF_COUNT) : active_size_reg;
        lo_c   = (range_low == '0) ? RW'(1) : range_low;
        hi_c   = (range_high > eff) ? eff : range_high;
        empty  = lo_c > hi_c;
        lowbit = idx_reg & (~idx_reg + IW'(1));
        idx_m1 = idx_reg - IW'(1);
        addr   = cmd.clr_step ? idx_reg[AW-1:0] : idx_m1[AW-1:0];
        mul_a  = cmd.mul_acc ? acc1_reg : v_reg;
        mul_half = cmd.mul_hi ? mul_a[63:32] : mul_a[31:0];
        pp     = PW'(mul_half) * PW'(mpos_reg);
        diff   = prod_reg - acc2_reg;
    end

    always_comb
    begin
        status.is_add   = (op_reg == lsegt_pkg::OP_ADD);
        status.is_query = (op_reg == lsegt_pkg::OP_QUERY);
        status.is_clear = (op_reg == lsegt_pkg::OP_CLEAR);
        status.empty    = empty_reg;
        status.upd_done = idx_reg > IW'(LEAF_COUNT);
        status.qry_done = (idx_reg == '0);
        status.clr_last = (idx_reg == IW'(LEAF_COUNT - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= lsegt_pkg::ACTIVE_SIZE_RESET;
            op_reg          <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            if (active_size_wr_en)
            begin
                active_size_reg <= active_size;
            end
            if (cmd.load)
            begin
                op_reg  <= opcode;
                idx_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            else if (cmd.upd_setup)
            begin
                idx_reg <= cmd.second ? hi_reg + IW'(1) : lo_reg;
            end
            else if (cmd.upd_wr)
            begin
                idx_reg <= idx_reg + lowbit;
            end
            else if (cmd.qry_setup)
            begin
                idx_reg <= cmd.second ? lo_reg - IW'(1) : hi_reg;
            end
            else if (cmd.qry_acc)
            begin
                idx_reg <= idx_reg - lowbit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            empty_reg <= empty;
            lo_reg    <= IW'(lo_c);
            hi_reg    <= IW'(hi_c);
            mpos_reg  <= IW'(lo_c) - IW'(1);
            v_reg     <= SW'(add_value);
            total_reg <= '0;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= SW'(pp);
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + {pp[31:0], 32'd0};
        end
        if (cmd.upd_setup)
        begin
            d1_reg <= cmd.second ? SW'(0) - v_reg : v_reg;
            d2_reg <= cmd.second ? SW'(0) - prod_reg : prod_reg;
            mpos_reg <= hi_reg;
        end
        if (cmd.qry_setup)
        begin
            acc1_reg <= '0;
            acc2_reg <= '0;
            mpos_reg <= cmd.second ? lo_reg - IW'(1) : hi_reg;
        end
        if (cmd.qry_acc)
        begin
            acc1_reg <= acc1_reg + rdata_reg[SW-1:0];
            acc2_reg <= acc2_reg + rdata_reg[SW*2-1:SW];
        end
        if (cmd.combine)
        begin
            total_reg <= cmd.second ? total_reg - diff : total_reg + diff;
        end
        if (cmd.out_load)
        begin
            sum_reg <= total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[addr] <= '0;
        end
        else if (cmd.upd_wr)
        begin
            mem[addr] <= {rdata_reg[SW*2-1:SW] + d2_reg, rdata_reg[SW-1:0] + d1_reg};
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign range_sum = sum_reg;

endmodule

// File: rtl/lsegt_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// lsegt_ctrl: operation sequencer
// Steps the datapath through clearing, tree updates, prefix walks and
// result hand-off, and owns the input and output handshakes.
// ============================================================================
module lsegt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  lsegt_pkg::lsegt_status_t status,
    output lsegt_pkg::lsegt_cmd_t    cmd
);

    lsegt_pkg::lsegt_state_t state_reg, state_next;
    logic second_reg, second_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        cmd.second  = second_reg;
        in_ready    = 1'b0;
        case (state_reg)
            lsegt_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = lsegt_pkg::S_IDLE;
                end
            end
            lsegt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lsegt_pkg::S_DISPATCH;
                end
            end
            lsegt_pkg::S_DISPATCH:
            begin
                second_next = 1'b0;
                if (status.is_clear)
                begin
                    state_next = lsegt_pkg::S_CLEAR;
                end
                else if (status.is_add)
                begin
                    state_next = status.empty ? lsegt_pkg::S_IDLE : lsegt_pkg::S_AMUL_LO;
                end
                else if (status.is_query)
                begin
                    state_next = status.empty ? lsegt_pkg::S_DONE : lsegt_pkg::S_QSETUP;
                end
                else
                begin
                    state_next = lsegt_pkg::S_IDLE;
                end
            end
            lsegt_pkg::S_AMUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = lsegt_pkg::S_AMUL_HI;
            end
            lsegt_pkg::S_AMUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = lsegt_pkg::S_USETUP;
            end
            lsegt_pkg::S_USETUP:
            begin
                cmd.upd_setup = 1'b1;
                state_next    = lsegt_pkg::S_URD;
            end
            lsegt_pkg::S_URD:
            begin
                if (status.upd_done)
                begin
                    second_next = 1'b1;
                    state_next  = second_reg ? lsegt_pkg::S_IDLE : lsegt_pkg::S_AMUL_LO;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = lsegt_pkg::S_UWR;
                end
            end
            lsegt_pkg::S_UWR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = lsegt_pkg::S_URD;
            end
            lsegt_pkg::S_QSETUP:
            begin
                cmd.qry_setup = 1'b1;
                state_next    = lsegt_pkg::S_QRD;
            end
            lsegt_pkg::S_QRD:
            begin
                if (status.qry_done)
                begin
                    state_next = lsegt_pkg::S_QMUL_LO;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = lsegt_pkg::S_QACC;
                end
            end
            lsegt_pkg::S_QACC:
            begin
                cmd.qry_acc = 1'b1;
                state_next  = lsegt_pkg::S_QRD;
            end
            lsegt_pkg::S_QMUL_LO:
            begin
                cmd.mul_lo  = 1'b1;
                cmd.mul_acc = 1'b1;
                state_next  = lsegt_pkg::S_QMUL_HI;
            end
            lsegt_pkg::S_QMUL_HI:
            begin
                cmd.mul_hi  = 1'b1;
                cmd.mul_acc = 1'b1;
                state_next  = lsegt_pkg::S_QCOMB;
            end
            lsegt_pkg::S_QCOMB:
            begin
                cmd.combine = 1'b1;
                second_next = 1'b1;
                state_next  = second_reg ? lsegt_pkg::S_DONE : lsegt_pkg::S_QSETUP;
            end
            lsegt_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lsegt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lsegt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsegt_pkg::S_CLEAR;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/lazy_segment_tree_range_add_sum.sv
`timescale 1ns / 1ps
// One transaction at a time: an add, a query or a clear runs to completion before the
// next one is accepted, and an empty add returns to idle straight after dispatch.
// Each tree level takes a read state and a write or accumulate state, set by the single read/write node memory port.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the node memory
// while in_ready stays low.
// ============================================================================
// lazy_segment_tree_range_add_sum: range add and range sum engine
// Signed range add and wrapping 64-bit range sum over LEAF_COUNT counters.
// ============================================================================
module lazy_segment_tree_range_add_sum #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lsegt_pkg::OPCODE_W-1:0]        opcode,
    input  logic [lsegt_pkg::RANGE_W-1:0]         range_low,
    input  logic [lsegt_pkg::RANGE_W-1:0]         range_high,
    input  logic signed [lsegt_pkg::VALUE_W-1:0]  add_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lsegt_pkg::SUM_W-1:0]    range_sum,
    input  logic                                  active_size_wr_en,
    input  logic [lsegt_pkg::SIZE_W-1:0]          active_size
);

    lsegt_pkg::lsegt_cmd_t    cmd;
    lsegt_pkg::lsegt_status_t status;

    lsegt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lsegt_dp #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .opcode            (opcode),
        .range_low         (range_low),
        .range_high        (range_high),
        .add_value         (add_value),
        .active_size_wr_en (active_size_wr_en),
        .active_size       (active_size),
        .range_sum         (range_sum)
    );

endmodule

// File: rtl/lsegt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lsegt_checker: port-level checks
// Output handshake rules and one-transaction-at-a-time acceptance.
// ============================================================================
module lsegt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [lsegt_pkg::OPCODE_W-1:0]     opcode,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [lsegt_pkg::SUM_W-1:0]        range_sum
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result withdrawn before it was taken.");

    a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(range_sum))
        else $error("Result changed while stalled.");

    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Second transaction accepted back to back.");

    a_clear_busy : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == lsegt_pkg::OP_CLEAR |-> ##2 !in_ready)
        else $error("Clear did not hold off new transactions.");

endmodule

bind lazy_segment_tree_range_add_sum lsegt_checker u_lsegt_checker (.*);

// File: tb/lazy_segment_tree_range_add_sum_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for lazy_segment_tree_range_add_sum
// Drives add, query, clear and unused-opcode transactions with random idling on both sides.
// Every query result is compared with a flat array of counters kept in the
// testbench. The run covers several active_size settings, including 1 and
// the largest value, 2047.
// ============================================================================
module lazy_segment_tree_range_add_sum_tb;

    localparam int LEAVES    = 1024;
    localparam int CYC_LIMIT = 2000000;
    localparam int SETTLE    = 2 * LEAVES + 200;
    localparam logic [lsegt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [lsegt_pkg::OPCODE_W-1:0]       opcode;
    logic [lsegt_pkg::RANGE_W-1:0]        range_low;
    logic [lsegt_pkg::RANGE_W-1:0]        range_high;
    logic signed [lsegt_pkg::VALUE_W-1:0] add_value;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [lsegt_pkg::SUM_W-1:0]   range_sum;
    logic                                 active_size_wr_en;
    logic [lsegt_pkg::SIZE_W-1:0]         active_size;

    logic [lsegt_pkg::SUM_W-1:0]  counters [1:LEAVES];
    logic [lsegt_pkg::SIZE_W-1:0] size_reg;
    logic [lsegt_pkg::SUM_W-1:0]  pending_sums [$];
    int                           failures;
    int                           cycles;
    bit                           calm;
    bit                           hold_out;

    typedef struct {
        logic [lsegt_pkg::OPCODE_W-1:0] op;
        int                             lo;
        int                             hi;
        int                             val;
        bit                             known;
        logic [lsegt_pkg::SUM_W-1:0]    sum;
    } stim_row_t;

    lazy_segment_tree_range_add_sum #(.LEAF_COUNT(LEAVES)) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .range_low         (range_low),
        .range_high        (range_high),
        .add_value         (add_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .range_sum         (range_sum),
        .active_size_wr_en (active_size_wr_en),
        .active_size       (active_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [lsegt_pkg::SUM_W-1:0] predict_sum(
        logic [lsegt_pkg::OPCODE_W-1:0] op, int lo, int hi, int val);
        int                          eff;
        int                          a;
        int                          b;
        logic [lsegt_pkg::SUM_W-1:0] acc;
        eff = (size_reg > LEAVES) ? LEAVES : size_reg;
        a = (lo < 1) ? 1 : lo;
        b = (hi > eff) ? eff : hi;
        acc = '0;
        if (op == lsegt_pkg::OP_CLEAR)
        begin
            for (int i = 1; i <= LEAVES; i++)
                counters[i] = '0;
        end
        else if (op == lsegt_pkg::OP_ADD || op == lsegt_pkg::OP_QUERY)
        begin
            for (int i = a; i <= b; i++)
            begin
                if (op == lsegt_pkg::OP_ADD)
                    counters[i] = counters[i] + {{32{val[31]}}, val[31:0]};
                else
                    acc = acc + counters[i];
            end
        end
        return acc;
    endfunction

    task automatic send(logic [lsegt_pkg::OPCODE_W-1:0] op, int lo, int hi, int val);
        logic [lsegt_pkg::SUM_W-1:0] s;
        while (!calm && $urandom_range(99) < 24)
            @(posedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        range_low  <= lo[lsegt_pkg::RANGE_W-1:0];
        range_high <= hi[lsegt_pkg::RANGE_W-1:0];
        add_value  <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        s = predict_sum(op, lo, hi, val);
        if (op == lsegt_pkg::OP_QUERY)
            pending_sums = {pending_sums, s};
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_and_write(int sz);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        active_size_wr_en <= 1'b1;
        active_size       <= sz[lsegt_pkg::SIZE_W-1:0];
        @(posedge clk);
        active_size_wr_en <= 1'b0;
        size_reg = sz[lsegt_pkg::SIZE_W-1:0];
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $error("range_sum: no result expected, actual %h", range_sum);
                    failures++;
                end
                else
                begin
                    if (range_sum !== pending_sums[0])
                    begin
                        $error("range_sum: expected %h, actual %h", pending_sums[0],
                               range_sum);
                        failures++;
                    end
                    void'(pending_sums.pop_front());
                end
            end
            out_ready <= hold_out ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        int        op_pick;
        int        lo;
        int        hi;
        int        sizes [5];
        failures = 0;
        calm = 1'b0;
        hold_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = lsegt_pkg::OP_ADD;
        range_low = '0;
        range_high = '0;
        add_value = '0;
        active_size_wr_en = 1'b0;
        active_size = lsegt_pkg::ACTIVE_SIZE_RESET;
        size_reg = lsegt_pkg::ACTIVE_SIZE_RESET;
        for (int i = 1; i <= LEAVES; i++)
            counters[i] = '0;
        rows = '{
            '{lsegt_pkg::OP_QUERY, 1, 1024, 0, 1, 64'd0},
            '{lsegt_pkg::OP_ADD, 1, 1024, 1, 0, 0},
            '{lsegt_pkg::OP_QUERY, 1, 1024, 0, 1, 64'd1024},
            '{lsegt_pkg::OP_ADD, 0, 2047, 32'h7fffffff, 0, 0},
            '{lsegt_pkg::OP_QUERY, 0, 2047, 0, 0, 0},
            '{lsegt_pkg::OP_ADD, 5, 5, 32'h80000000, 0, 0},
            '{lsegt_pkg::OP_QUERY, 5, 5, 0, 0, 0},
            '{lsegt_pkg::OP_QUERY, 9, 3, 0, 1, 64'd0},
            '{lsegt_pkg::OP_ADD, 9, 3, 77, 0, 0},
            '{lsegt_pkg::OP_QUERY, 1025, 2047, 0, 1, 64'd0},
            '{OP_UNUSED, 1, 1024, 99, 0, 0},
            '{lsegt_pkg::OP_QUERY, 1, 1, 0, 0, 0},
            '{lsegt_pkg::OP_ADD, 512, 513, -3, 0, 0},
            '{lsegt_pkg::OP_QUERY, 500, 600, 0, 0, 0},
            '{lsegt_pkg::OP_ADD, 1024, 1024, 32'h55555555, 0, 0},
            '{lsegt_pkg::OP_QUERY, 1000, 1024, 0, 0, 0},
            '{lsegt_pkg::OP_CLEAR, 0, 0, 0, 0, 0},
            '{lsegt_pkg::OP_QUERY, 1, 1024, 0, 1, 64'd0},
            '{lsegt_pkg::OP_ADD, 1, 3, -1, 0, 0},
            '{lsegt_pkg::OP_QUERY, 2, 1024, 0, 0, 0}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known && r.op == lsegt_pkg::OP_QUERY)
            begin
                while (pending_sums.size() != 0)
                    @(posedge clk);
                send(r.op, r.lo, r.hi, r.val);
                if (pending_sums[0] !== r.sum)
                begin
                    $error("range_sum: expected %h, actual %h", r.sum, pending_sums[0]);
                    failures++;
                end
            end
            else
                send(r.op, r.lo, r.hi, r.val);
        end
        sizes = '{1, 2047, 37, 1024, 700};
        foreach (sizes[p])
        begin
            drain_and_write(sizes[p]);
            if (p == 2)
            begin
                calm = 1'b1;
                hold_out = 1'b1;
            end
            else
            begin
                calm = 1'b0;
                hold_out = 1'b0;
            end
            for (int n = 0; n < 360; n++)
            begin
                op_pick = $urandom_range(99);
                if ($urandom_range(3) == 0)
                begin
                    lo = $urandom_range(2047);
                    hi = $urandom_range(2047);
                end
                else
                begin
                    lo = $urandom_range(1024, 0);
                    hi = lo + $urandom_range(64);
                    if ($urandom_range(3) == 0)
                        hi = $urandom_range(1024, lo);
                end
                if (op_pick < 48)
                    send(lsegt_pkg::OP_ADD, lo, hi, $urandom());
                else if (op_pick < 96)
                    send(lsegt_pkg::OP_QUERY, lo, hi, $urandom());
                else if (op_pick < 98)
                    send(lsegt_pkg::OP_CLEAR, lo, hi, $urandom());
                else
                    send(OP_UNUSED, lo, hi, $urandom());
            end
        end
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lsegt_pkg.sv
rtl/lsegt_dp.sv
rtl/lsegt_ctrl.sv
rtl/lazy_segment_tree_range_add_sum.sv
rtl/lsegt_checker.sv
tb/lazy_segment_tree_range_add_sum_tb.sv
